// ===== design/atcr_pkg.sv =====
package atcr_pkg;
   localparam logic [2:0] KIND_EMPTY  = 3'd0;
   localparam logic [2:0] KIND_SOLID  = 3'd1;
   localparam logic [2:0] KIND_ONEWAY = 3'd2;
   localparam logic [2:0] KIND_LADDER = 3'd3;
   localparam logic [2:0] KIND_SPIKE  = 3'd4;

   localparam logic [1:0] CSR_MAP_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_MAP_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_TILE_LOG2  = 2'd2;

   // Wide enough for any tile index or shifted edge of a 20-bit position.
   localparam int IDX_W = 24;

   typedef enum logic [8:0] {
      ST_CLEAR  = 9'b000000001,
      ST_IDLE   = 9'b000000010,
      ST_XSETUP = 9'b000000100,
      ST_XSCAN  = 9'b000001000,
      ST_YSETUP = 9'b000010000,
      ST_YSCAN  = 9'b000100000,
      ST_CENTER = 9'b001000000,
      ST_CWAIT  = 9'b010000000,
      ST_OUT    = 9'b100000000
   } state_type;
endpackage

// ===== design/aabb_tile_collision_resolver.sv =====
// Tile map collision resolver.
// req_ channel: one beat is either a tile write (func 0) or a box resolve
// (func 1). A tile write produces no response; a resolve produces one
// rsp_ beat carrying the new position, speeds and the three flags.
// csr_ channel: index 0 map_width, 1 map_height, 2 tile_size_log2; write
// only while the block is idle. Writes are taken whenever reset is low.
// A resolve walks the tiles along the leading column, then the leading
// row, then the tile under the centre, reading the map memory through a
// single address computation; each tile read is consumed before the next
// is issued. No tiles are read on an axis with zero speed, a scan stops
// at the first blocking tile, and the centre check is skipped once a
// ladder has been seen. A tile write leaves the block idle and ready for
// the next beat. After a resolve the next beat is taken only once the
// response is accepted, as req_tready is low while rsp_tvalid is high.
// After reset the whole map memory (MAP_COLS_MAX*MAP_ROWS_MAX entries) is
// cleared one entry a cycle; req_tready stays low meanwhile.
// A stalled response is held in its register until rsp_tready is high.
module aabb_tile_collision_resolver #(
   parameter int MAP_COLS_MAX = 64,
   parameter int MAP_ROWS_MAX = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tile_col[5:0], tile_row[11:6], tile_kind[14:12], box_left[34:15],
   // box_top[54:35], box_width[66:55], box_height[78:67], speed_x[90:79],
   // speed_y[102:91], zero fill to 104 bits
   input  logic [103:0] req_tdata,
   input  logic        req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // new_left[19:0], new_top[39:20], new_speed_x[51:40], new_speed_y[63:52],
   // landed[64], ladder_seen[65], spike_seen[66], zero fill to 72 bits
   output logic [71:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_data
);
   localparam int DEPTH = MAP_COLS_MAX * MAP_ROWS_MAX;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = (MAP_COLS_MAX > 1) ? $clog2(MAP_COLS_MAX) : 1;
   localparam int IW = atcr_pkg::IDX_W;

   logic [2:0] mem [DEPTH];
   logic [2:0] rd_ff;

   atcr_pkg::state_type state_ff, state_in;
   logic [AW:0] clr_ff, clr_in;
   logic [6:0] mw_ff, mh_ff;
   logic [2:0] tl_ff;

   logic signed [19:0] x_ff, x_in, y_ff, y_in;
   logic [11:0] w_ff, h_ff;
   logic signed [11:0] vx_ff, vx_in, vy_ff, vy_in;
   logic g_ff, g_in, l_ff, l_in, s_ff, s_in;
   logic signed [IW-1:0] fix_ff, fix_in, i_ff, i_in, hi_ff, hi_in;
   logic pend_ff, pend_in;   // a read issued last cycle returns in rd_ff
   logic last_ff, last_in;
   logic [71:0] out_ff, out_in;
   logic ov_ff, ov_in;

   logic [3:0] sh;
   assign sh = {1'b0, tl_ff} + 4'd4;

   // Shared address unit: one bounds check and address per cycle.
   logic signed [IW-1:0] qx, qy;
   logic outside;
   logic [AW-1:0] raddr;
   logic [6:0] mwc, mhc;
   always_comb begin
      mwc = (32'(mw_ff) > MAP_COLS_MAX) ? 7'(MAP_COLS_MAX) : mw_ff;
      mhc = (32'(mh_ff) > MAP_ROWS_MAX) ? 7'(MAP_ROWS_MAX) : mh_ff;
      outside = qx < 0 || qy < 0 || qx >= $signed({1'b0, mwc}) ||
                qy >= $signed({1'b0, mhc});
      raddr = AW'(qy * MAP_COLS_MAX + qx);
   end

   logic oob_ff;   // registered outside flag
   logic [2:0] kind;
   assign kind = oob_ff ? atcr_pkg::KIND_SOLID : rd_ff;

   logic signed [IW-1:0] ext;
   logic signed [IW:0] ctr;
   logic signed [IW-1:0] x_e, y_e, w_e, h_e;
   logic hit;

   assign req_tready = (state_ff == atcr_pkg::ST_IDLE) && !ov_ff;
   assign csr_ready = !reset;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata = out_ff;

   always_ff @(posedge clock) begin
      if (state_ff == atcr_pkg::ST_CLEAR)
         mem[clr_ff[AW-1:0]] <= atcr_pkg::KIND_EMPTY;
      else if (req_tvalid && req_tready && !req_tuser &&
               32'(req_tdata[5:0]) < MAP_COLS_MAX &&
               32'(req_tdata[11:6]) < MAP_ROWS_MAX)
         mem[AW'(32'(req_tdata[11:6]) * MAP_COLS_MAX + 32'(req_tdata[5:0]))]
            <= req_tdata[14:12];
      rd_ff <= mem[raddr];
      oob_ff <= outside;
   end

   always_comb begin
      state_in = state_ff; clr_in = clr_ff;
      x_in = x_ff; y_in = y_ff; vx_in = vx_ff; vy_in = vy_ff;
      g_in = g_ff; l_in = l_ff; s_in = s_ff;
      fix_in = fix_ff; i_in = i_ff; hi_in = hi_ff;
      pend_in = 1'b0; last_in = last_ff; out_in = out_ff; ov_in = ov_ff;
      qx = i_ff; qy = fix_ff;
      ext = '0; ctr = '0; hit = 1'b0;
      x_e = IW'(x_ff); y_e = IW'(y_ff);
      w_e = IW'({1'b0, w_ff}); h_e = IW'({1'b0, h_ff});
      if (ov_ff && rsp_tready) ov_in = 1'b0;
      case (state_ff)
         atcr_pkg::ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == DEPTH - 1) state_in = atcr_pkg::ST_IDLE;
         end
         atcr_pkg::ST_IDLE: begin
            if (req_tvalid && req_tready && req_tuser) begin
               x_in = req_tdata[34:15]; y_in = req_tdata[54:35];
               vx_in = req_tdata[90:79]; vy_in = req_tdata[102:91];
               g_in = 1'b0; l_in = 1'b0; s_in = 1'b0;
               state_in = atcr_pkg::ST_XSETUP;
            end
         end
         atcr_pkg::ST_XSETUP: begin
            if (vx_ff == 0) state_in = atcr_pkg::ST_YSETUP;
            else begin
               x_in = x_ff + 20'(vx_ff);
               ext = IW'(x_in) + ((vx_ff > 0) ? w_e - IW'(1) : '0);
               fix_in = ext >>> sh;
               i_in = y_e >>> sh;
               hi_in = (y_e + h_e - IW'(1)) >>> sh;
               state_in = atcr_pkg::ST_XSCAN;
               last_in = 1'b0;
            end
         end
         atcr_pkg::ST_XSCAN: begin
            // Issue read (column fix, row i) then consume it next cycle.
            qx = fix_ff; qy = i_ff;
            if (pend_ff) begin
               if (kind == atcr_pkg::KIND_SPIKE) s_in = 1'b1;
               if (kind == atcr_pkg::KIND_LADDER) l_in = 1'b1;
               if (kind == atcr_pkg::KIND_SOLID) begin
                  x_in = (vx_ff > 0) ? 20'((fix_ff <<< sh) - w_e)
                                     : 20'((fix_ff + 1) <<< sh);
                  vx_in = '0;
                  state_in = atcr_pkg::ST_YSETUP;
               end else if (last_ff) state_in = atcr_pkg::ST_YSETUP;
            end else if (i_ff > hi_ff) state_in = atcr_pkg::ST_YSETUP;
            else begin
               pend_in = 1'b1; last_in = (i_ff == hi_ff); i_in = i_ff + IW'(1);
            end
         end
         atcr_pkg::ST_YSETUP: begin
            if (vy_ff == 0) state_in = atcr_pkg::ST_CENTER;
            else begin
               y_in = y_ff + 20'(vy_ff);
               ext = IW'(y_in) + ((vy_ff > 0) ? h_e - IW'(1) : '0);
               fix_in = ext >>> sh;
               i_in = x_e >>> sh;
               hi_in = (x_e + w_e - IW'(1)) >>> sh;
               state_in = atcr_pkg::ST_YSCAN;
               last_in = 1'b0;
            end
         end
         atcr_pkg::ST_YSCAN: begin
            qx = i_ff; qy = fix_ff;
            if (pend_ff) begin
               if (kind == atcr_pkg::KIND_SPIKE) s_in = 1'b1;
               if (kind == atcr_pkg::KIND_LADDER) l_in = 1'b1;
               hit = kind == atcr_pkg::KIND_SOLID ||
                     (vy_ff > 0 && kind == atcr_pkg::KIND_ONEWAY);
               if (hit) begin
                  if (vy_ff > 0) begin
                     y_in = 20'((fix_ff <<< sh) - h_e); g_in = 1'b1;
                  end else y_in = 20'((fix_ff + 1) <<< sh);
                  vy_in = '0;
                  state_in = atcr_pkg::ST_CENTER;
               end else if (last_ff) state_in = atcr_pkg::ST_CENTER;
            end else if (i_ff > hi_ff) state_in = atcr_pkg::ST_CENTER;
            else begin
               pend_in = 1'b1; last_in = (i_ff == hi_ff); i_in = i_ff + IW'(1);
            end
         end
         atcr_pkg::ST_CENTER: begin
            ctr = (IW+1)'(2 * x_e + w_e);
            i_in = IW'(ctr >>> (sh + 4'd1));
            ctr = (IW+1)'(2 * y_e + h_e);
            fix_in = IW'(ctr >>> (sh + 4'd1));
            state_in = l_ff ? atcr_pkg::ST_OUT : atcr_pkg::ST_CWAIT;
            last_in = 1'b0;
         end
         atcr_pkg::ST_CWAIT: begin
            // The read is issued while last_ff is low; its result is taken once last_ff is set.
            if (last_ff) begin
               l_in = kind == atcr_pkg::KIND_LADDER;
               state_in = atcr_pkg::ST_OUT;
            end else last_in = 1'b1;
         end
         atcr_pkg::ST_OUT: begin
            if (!ov_ff) begin
               out_in = {5'd0, s_ff, l_ff, g_ff, vy_ff, vx_ff, y_ff, x_ff};
               ov_in = 1'b1;
               state_in = atcr_pkg::ST_IDLE;
            end
         end
         default: state_in = atcr_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= atcr_pkg::ST_CLEAR;
         clr_ff <= '0;
         ov_ff <= 1'b0;
         pend_ff <= 1'b0;
         mw_ff <= 7'd64; mh_ff <= 7'd64; tl_ff <= 3'd4;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; ov_ff <= ov_in;
         pend_ff <= pend_in;
         if (csr_valid) begin
            case (csr_index)
               atcr_pkg::CSR_MAP_WIDTH:  mw_ff <= csr_data;
               atcr_pkg::CSR_MAP_HEIGHT: mh_ff <= csr_data;
               atcr_pkg::CSR_TILE_LOG2:  tl_ff <= csr_data[2:0];
               default: ;
            endcase
         end
      end
      x_ff <= x_in; y_ff <= y_in; vx_ff <= vx_in; vy_ff <= vy_in;
      g_ff <= g_in; l_ff <= l_in; s_ff <= s_in;
      fix_ff <= fix_in; i_ff <= i_in; hi_ff <= hi_in;
      last_ff <= last_in; out_ff <= out_in;
      if (state_ff == atcr_pkg::ST_IDLE) begin
         w_ff <= req_tdata[66:55]; h_ff <= req_tdata[78:67];
      end
   end
endmodule
